// ----- src/windowed_latency_average_monitor_unit_defines.svh -----
// Assertion helpers used by the datapath (wlam_dpath).
`ifndef WINDOWED_LATENCY_AVERAGE_MONITOR_UNIT_DEFINES_SVH
`define WINDOWED_LATENCY_AVERAGE_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WLAM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WLAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wlam_pkg.sv -----
package wlam_pkg;

    localparam int WINDOW_DEPTH = 128;
    localparam int SAMPLE_BITS  = 16;
    localparam int CHANNELS     = 4;
    localparam int FIELD_W      = 16;
    localparam int CODE_W       = 3;

    localparam int SLOT_W   = $clog2(WINDOW_DEPTH);
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = SAMPLE_BITS + SLOT_W;
    localparam int ITER_W   = $clog2(SUM_W);
    localparam int MEM_W    = CHANNELS * SAMPLE_BITS;
    localparam int IN_W     = CHANNELS * FIELD_W;
    localparam int OUT_RAW  = CHANNELS * FIELD_W + CODE_W;
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;
    localparam int REG_IDX_W = 2;

    localparam int CH_CAPTURE  = 0;
    localparam int CH_DETECT   = 1;
    localparam int CH_TRACKING = 2;
    localparam int CH_OUTPUT   = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DETECT_THR   = 2'd0,
        REG_CAPTURE_THR  = 2'd1,
        REG_TRACKING_THR = 2'd2,
        REG_OUTPUT_THR   = 2'd3
    } t_reg_idx;

    localparam logic [FIELD_W-1:0] RST_DETECT_THR   = 16'd2560;
    localparam logic [FIELD_W-1:0] RST_CAPTURE_THR  = 16'd512;
    localparam logic [FIELD_W-1:0] RST_TRACKING_THR = 16'd512;
    localparam logic [FIELD_W-1:0] RST_OUTPUT_THR   = 16'd256;

    typedef enum logic [CODE_W-1:0] {
        CODE_NONE     = 3'd0,
        CODE_DETECT   = 3'd1,
        CODE_CAPTURE  = 3'd2,
        CODE_TRACKING = 3'd3,
        CODE_OUTPUT   = 3'd4
    } t_code;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_INIT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic update;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_busy;
    } t_stat;

endpackage

// ----- src/wlam_ctrl.sv -----
module wlam_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  wlam_pkg::t_stat i_stat,
    output wlam_pkg::t_cmd  o_cmd
);
    import wlam_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_UPDATE;
            S_UPDATE: n_state = S_INIT;
            S_INIT:   n_state = S_DIV;
            S_DIV:    if (i_stat.div_last) n_state = S_DONE;
            S_DONE:   if (!i_stat.out_busy) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
            end
            S_UPDATE: o_cmd.update   = 1'b1;
            S_INIT:   o_cmd.div_init = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_DONE:   o_cmd.out_load = !i_stat.out_busy;
            default: begin
                o_cmd      = '0;
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/wlam_dpath.sv -----
`include "windowed_latency_average_monitor_unit_defines.svh"

module wlam_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wlam_pkg::t_cmd              i_cmd,
    output wlam_pkg::t_stat             o_stat,
    input  logic [wlam_pkg::IN_W-1:0]   i_s_tdata,
    input  logic                        i_cfg_wr_en,
    input  logic [wlam_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [wlam_pkg::FIELD_W-1:0] i_cfg_wdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [wlam_pkg::OUT_W-1:0]  o_m_tdata
);
    import wlam_pkg::*;

    logic [MEM_W-1:0]       r_mem [WINDOW_DEPTH];
    logic [MEM_W-1:0]       r_rd;
    logic [SAMPLE_BITS-1:0] r_samp [CHANNELS];
    logic [SAMPLE_BITS-1:0] w_old [CHANNELS];
    logic [MEM_W-1:0]       w_new_word;
    logic [SLOT_W-1:0]      r_slot;
    logic                   r_full;
    logic [SUM_W-1:0]       r_sum [CHANNELS];
    logic [SUM_W-1:0]       n_sum [CHANNELS];
    logic [FIELD_W-1:0]     r_thr [CHANNELS];
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_rem [CHANNELS];
    logic [SUM_W-1:0]       r_quo [CHANNELS];
    logic [CNT_W-1:0]       n_rem [CHANNELS];
    logic [SUM_W-1:0]       n_quo [CHANNELS];
    logic [CNT_W:0]         w_trial [CHANNELS];
    logic [ITER_W-1:0]      r_iter;
    logic                   r_div_active;
    logic                   r_out_valid;
    logic [FIELD_W-1:0]     r_out_mean [CHANNELS];
    t_code                  r_out_code;
    t_code                  w_code;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_old[c] = r_rd[c*SAMPLE_BITS +: SAMPLE_BITS];
            w_new_word[c*SAMPLE_BITS +: SAMPLE_BITS] = r_samp[c];
            n_sum[c] = r_sum[c] + SUM_W'(r_samp[c])
                       - (r_full ? SUM_W'(w_old[c]) : SUM_W'(0));
        end
    end

    // window storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_rd <= r_mem[r_slot];
        end
        if (i_cmd.update) begin
            r_mem[r_slot] <= w_new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_samp[c] <= SAMPLE_BITS'(i_s_tdata[c*FIELD_W +: FIELD_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_full <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_cmd.update) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= n_sum[c];
            end
            if (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
                r_slot <= '0;
                r_full <= 1'b1;
            end else begin
                r_slot <= r_slot + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[CH_DETECT]   <= RST_DETECT_THR;
            r_thr[CH_CAPTURE]  <= RST_CAPTURE_THR;
            r_thr[CH_TRACKING] <= RST_TRACKING_THR;
            r_thr[CH_OUTPUT]   <= RST_OUTPUT_THR;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DETECT_THR:   r_thr[CH_DETECT]   <= i_cfg_wdata;
                REG_CAPTURE_THR:  r_thr[CH_CAPTURE]  <= i_cfg_wdata;
                REG_TRACKING_THR: r_thr[CH_TRACKING] <= i_cfg_wdata;
                REG_OUTPUT_THR:   r_thr[CH_OUTPUT]   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // restoring divide, one quotient bit per lane per cycle
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_trial[c] = {r_rem[c], r_quo[c][SUM_W-1]};
            if (w_trial[c] >= {1'b0, r_count}) begin
                n_rem[c] = CNT_W'(w_trial[c] - {1'b0, r_count});
                n_quo[c] = {r_quo[c][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[c] = CNT_W'(w_trial[c]);
                n_quo[c] = {r_quo[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_count <= r_full ? CNT_W'(WINDOW_DEPTH) : CNT_W'(r_slot);
            for (int c = 0; c < CHANNELS; c++) begin
                r_rem[c] <= '0;
                r_quo[c] <= r_sum[c];
            end
        end else if (i_cmd.div_step) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_rem[c] <= n_rem[c];
                r_quo[c] <= n_quo[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter       <= '0;
            r_div_active <= 1'b0;
        end else if (i_cmd.div_init) begin
            r_iter       <= '0;
            r_div_active <= 1'b1;
        end else if (i_cmd.div_step) begin
            r_iter <= r_iter + ITER_W'(1);
            if (o_stat.div_last) begin
                r_div_active <= 1'b0;
            end
        end
    end

    assign o_stat.div_last = (r_iter == ITER_W'(SUM_W - 1));
    assign o_stat.out_busy = r_out_valid && !i_m_tready;

    always_comb begin
        priority if (r_quo[CH_DETECT] > SUM_W'(r_thr[CH_DETECT])) begin
            w_code = CODE_DETECT;
        end else if (r_quo[CH_CAPTURE] > SUM_W'(r_thr[CH_CAPTURE])) begin
            w_code = CODE_CAPTURE;
        end else if (r_quo[CH_TRACKING] > SUM_W'(r_thr[CH_TRACKING])) begin
            w_code = CODE_TRACKING;
        end else if (r_quo[CH_OUTPUT] > SUM_W'(r_thr[CH_OUTPUT])) begin
            w_code = CODE_OUTPUT;
        end else begin
            w_code = CODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_out_mean[c] <= FIELD_W'(r_quo[c]);
            end
            r_out_code <= w_code;
        end
    end

    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_m_tdata = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            o_m_tdata[c*FIELD_W +: FIELD_W] = r_out_mean[c];
        end
        o_m_tdata[CHANNELS*FIELD_W +: CODE_W] = r_out_code;
    end

    `WLAM_ASSERT_IMPL(a_rem_below_count, r_div_active, r_rem[0] < r_count, "remainder out of range")
    `WLAM_ASSERT_IMPL(a_count_nonzero, r_div_active, r_count != '0, "zero divisor")
    `WLAM_ASSERT_IMPL(a_out_free, i_cmd.out_load, !r_out_valid || i_m_tready, "output overwritten")
    `WLAM_ASSERT_NEXT(a_full_sticky, r_full, r_full, "window full flag dropped")

endmodule

// ----- src/windowed_latency_average_monitor_unit.sv -----
// Four-channel windowed latency monitor. Each input beat carries four 16-bit samples
// (capture, detection, tracking, injection; ms with 8 fraction bits); the block keeps the
// last 128 beats in a window memory with a running sum per channel and returns one
// output beat per input beat with the four truncated window means and a bottleneck code
// (first of detection, capture, tracking, injection whose mean exceeds its threshold).
// The window read happens at the accepting edge; the result register loads after the
// sum update, the divider load and 23 steps of the per-channel restoring divider (one
// quotient bit per cycle over the sum width), once the output register is free. A new
// beat is accepted only once the result sits in the output register, so the block does
// not take a new beat while one is in flight; a stalled output holds the block. Write
// thresholds only while no beat is in flight.
module windowed_latency_average_monitor_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // capture_sample, detect_sample, tracking_sample, output_sample
    input  logic [wlam_pkg::IN_W-1:0]      i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // capture_mean, detect_mean, tracking_mean, output_mean, bottleneck_code, zero pad
    output logic [wlam_pkg::OUT_W-1:0]     o_m_tdata,
    input  logic                           i_cfg_wr_en,
    input  logic [wlam_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [wlam_pkg::FIELD_W-1:0]   i_cfg_wdata
);
    import wlam_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    wlam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    wlam_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
